// ----- rtl/core/plfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plfc_pkg
// shared constants and helpers for the precision limited float compare unit
// ----------------------------------------------------------------------------
package plfc_pkg;

    localparam int SGL_MANT = 23;
    localparam int DBL_MANT = 52;
    localparam int SGL_BIAS = 127;
    localparam int DBL_BIAS = 1023;

    localparam logic [1:0] KIND_SS    = 2'd0;
    localparam logic [1:0] KIND_DD    = 2'd1;
    localparam logic [1:0] KIND_MIXED = 2'd2;

    localparam int IN_TDATA_W = 144;  // 64 + 7 + 1 + 64 + 7 + 1 = 144, already whole bytes
    localparam int IN_TUSER_W = 2;

    // clean precision: negative means full (-1)
    typedef struct packed {
        logic       full;
        logic [5:0] p;
    } prec_t;

    function automatic prec_t prec_of(input logic [6:0] raw);
        prec_t r;
        r.full = raw[6];
        r.p    = raw[5:0];
        return r;
    endfunction

    // keep top p bits of an mbits wide mantissa, p below mbits
    function automatic logic [63:0] keep_top(input logic [63:0] bits, input logic [5:0] p,
                                             input logic [5:0] mbits);
        logic [63:0] mask;
        mask = ~((64'd1 << (mbits - p)) - 64'd1);
        return bits & mask;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/precision_limited_float_compare_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// precision_limited_float_compare_unit
// equality of two ieee patterns up to the common stored mantissa precision
// ----------------------------------------------------------------------------
// one word in, one word out, one word per cycle sustained while m_axis_tready
// stays high. each accepted word is captured in an input register, masking /
// rounding / compare run in one combinational pass, and the flag lands in an
// output register. a one-entry skid buffer behind the output register takes
// the word from the input register while a result waits, so s_axis_tready
// comes straight from a register and back-to-back words flow while
// m_axis_tready stays high. under a long stall three words fit inside (output,
// skid, input) before s_axis_tready drops.
// tuser carries kind; tdata carries value_a, precision_a, a_is_null, value_b,
// precision_b, b_is_null from the lowest bit up.
module precision_limited_float_compare_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [63:0] value_a, [70:64] precision_a, [71] a_is_null,
    // [135:72] value_b, [142:136] precision_b, [143] b_is_null
    input  wire logic [plfc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  wire logic [plfc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] equal, [7:1] zero
    output logic [7:0]                             m_axis_tdata
);

    // input stage
    logic                            in_v_reg;
    logic [plfc_pkg::IN_TDATA_W-1:0] in_d_reg;
    logic [plfc_pkg::IN_TUSER_W-1:0] in_k_reg;
    // output register and skid
    logic out_v_reg, out_d_reg, skid_v_reg, skid_d_reg;

    logic adv;
    assign adv = !out_v_reg || m_axis_tready;
    assign s_axis_tready = !skid_v_reg;

    // ---------------- compare datapath ----------------
    logic [63:0] a, b, a_w, b_r, a_x, b_x;
    plfc_pkg::prec_t pa, pb;
    logic an, bn, eq;
    logic pa_lt, pb_lt;

    // round double to single and widen back
    logic [10:0] de;
    logic [51:0] dm;
    logic [52:0] sig;
    logic [23:0] r;
    logic [28:0] rem;
    logic        rup;
    logic [24:0] rr;
    logic [11:0] fe;    // signed offset exp
    logic [12:0] ue_sh; // shift amount for subnormal path
    logic [53:0] k;
    logic [53:0] shrem;
    logic [53:0] half;
    logic [4:0]  t;
    logic [63:0] kk;

    always_comb begin
        a  = in_d_reg[63:0];
        b  = in_d_reg[135:72];
        pa = plfc_pkg::prec_of(in_d_reg[70:64]);
        pb = plfc_pkg::prec_of(in_d_reg[142:136]);
        an = in_d_reg[71];
        bn = in_d_reg[143];
        // pa < pb with -1 as full
        pa_lt = !pa.full && (pb.full || pa.p < pb.p);
        pb_lt = !pb.full && (pa.full || pb.p < pa.p);

        // naive widening of a
        a_w = {a[31], 3'b000, a[30:23], a[22:0], 29'd0};
        if (a[31:0] != 32'd0) a_w[62:52] = {3'b000, a[30:23]} + 11'd896;

        // rounding of b
        de  = b[62:52];
        dm  = b[51:0];
        sig = {1'b1, dm};
        fe  = {1'b0, de} - 12'd896;
        r   = sig[52:29];
        rem = sig[28:0];
        rup = (rem > 29'h1000_0000) || (rem == 29'h1000_0000 && r[0]);
        rr  = {1'b0, r} + {24'd0, rup};
        ue_sh = 13'd926 - {2'd0, de};      // = -(ue+97)
        k = 54'd0; shrem = 54'd0; half = 54'd0; t = 5'd0; kk = 64'd0;
        if (de == 11'h7FF) begin
            if (dm == 52'd0) b_r = b;
            else b_r = {b[63], 11'h7FF, 1'b1, dm[50:29], 29'd0};
        end else if (de == 11'd0) begin
            b_r = {b[63], 63'd0};
        end else if (!fe[11] && fe != 12'd0) begin
            if (rr[24]) begin
                if (fe + 12'd1 >= 12'd255) b_r = {b[63], 11'h7FF, 52'd0};
                else b_r = {b[63], de + 11'd1, 23'd0, 29'd0};
            end else if (fe >= 12'd255) begin
                b_r = {b[63], 11'h7FF, 52'd0};
            end else begin
                b_r = {b[63], de, rr[22:0], 29'd0};
            end
        end else begin
            if (ue_sh <= 13'd54) begin
                k     = 54'({1'b0, sig} >> ue_sh[5:0]);
                shrem = {1'b0, sig} & ((54'd1 << ue_sh[5:0]) - 54'd1);
                half  = 54'd1 << (ue_sh[5:0] - 6'd1);
                if (shrem > half || (shrem == half && k[0])) k = k + 54'd1;
            end
            if (k == 54'd0) begin
                b_r = {b[63], 63'd0};
            end else begin
                for (int i = 1; i <= 23; i++) if (k[i]) t = 5'(i);
                kk  = (64'(k) - (64'd1 << t)) << (6'd52 - {1'b0, t});
                b_r = {b[63], 11'(t) + 11'd874, kk[51:0]};
            end
        end

        a_x = a; b_x = b;
        unique case (in_k_reg)
            plfc_pkg::KIND_SS: begin
                a_x = {32'd0, a[31:0]};
                b_x = {32'd0, b[31:0]};
                if (pa_lt && pa.p < 6'd23) b_x = plfc_pkg::keep_top(b_x, pa.p, 6'd23);
                if (pb_lt && pb.p < 6'd23) a_x = plfc_pkg::keep_top(a_x, pb.p, 6'd23);
            end
            plfc_pkg::KIND_MIXED: begin
                a_x = a_w;
                b_x = b_r;
                if (pa_lt || (pa.full && (pb.full || pb.p > 6'd23))) begin
                    if (pa.full) b_x = plfc_pkg::keep_top(b_x, 6'd23, 6'd52);
                    else if (pa.p < 6'd52) b_x = plfc_pkg::keep_top(b_x, pa.p, 6'd52);
                end
                if (pb_lt && pb.p < 6'd23) a_x = plfc_pkg::keep_top(a_x, pb.p, 6'd52);
            end
            default: begin
                if (pa_lt && pa.p < 6'd52) b_x = plfc_pkg::keep_top(b_x, pa.p, 6'd52);
                if (pb_lt && pb.p < 6'd52) a_x = plfc_pkg::keep_top(a_x, pb.p, 6'd52);
            end
        endcase
        eq = an ? bn : (a_x == b_x);
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            // input register hands its word to out or skid unless both are taken
            if (adv || s_axis_tready) begin
                in_v_reg <= s_axis_tvalid && s_axis_tready;
            end
            if (adv) begin
                out_v_reg <= in_v_reg || skid_v_reg;
                if (skid_v_reg) skid_v_reg <= in_v_reg;
            end else if (in_v_reg) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    // in_reg loads on every accepted word (tvalid while the skid is empty); its old word moves on to out or skid
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_d_reg <= s_axis_tdata;
            in_k_reg <= s_axis_tuser;
        end
        if (adv) begin
            out_d_reg <= skid_v_reg ? skid_d_reg : eq;
            if (skid_v_reg) skid_d_reg <= eq;
        end else if (in_v_reg && !skid_v_reg) begin
            skid_d_reg <= eq;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {7'd0, out_d_reg};

endmodule

`default_nettype wire

// ----- rtl/core/plfc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plfc_checker
// port level checks for the compare unit
// ----------------------------------------------------------------------------
module plfc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("nonzero pad bits");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("word lost");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |=> s_axis_tready)
        else $error("input blocked with empty output");
endmodule

bind precision_limited_float_compare_unit plfc_checker u_plfc_checker (.*);

`default_nettype wire
